// ----- src/srdg_pkg.sv -----
// ----------------------------------------------------------------------------
// srdg_pkg
// Shared types, constants and helpers for the stepper ramp delay generator.
// ----------------------------------------------------------------------------
package srdg_pkg;

   // divider operand width: ramp and step distances fit in 24 bits
   localparam int DIV_W         = 24;
   localparam int DIV_CNT_W     = $clog2(DIV_W);
   localparam int CFG_W         = 24;
   localparam int CSR_IDX_W     = 2;
   localparam int POS_WIDTH_DEF = 24;

   localparam logic [7:0] MAX_DELAY = 8'd255;
   localparam logic [7:0] MIN_DELAY = 8'd1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STEPS_PER_REV = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL         = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_END_POS       = 2'd2;

   // reset values of the registers
   localparam logic [15:0] SPR_RESET     = 16'd3200;
   localparam logic [7:0]  ACCEL_RESET   = 8'd100;
   localparam logic [23:0] END_POS_RESET = 24'd20000;

   typedef struct packed {
      logic [15:0] steps_per_rev;
      logic [7:0]  accel;
      logic [23:0] end_pos;
   } cfg_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   // saturate a quotient into the 1..255 delay range
   function automatic logic [7:0] clamp_delay(input logic [DIV_W-1:0] q);
      logic [7:0] d;
      if (q > DIV_W'(MAX_DELAY)) begin
         d = MAX_DELAY;
      end else if (q == '0) begin
         d = MIN_DELAY;
      end else begin
         d = q[7:0];
      end
      return d;
   endfunction

endpackage

// ----- src/srdg_intf.sv -----
// ----------------------------------------------------------------------------
// srdg request and response interfaces
// Valid/ready channels carrying step requests and step records.
// ----------------------------------------------------------------------------
interface srdg_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface srdg_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] delay;
   logic       direction;
   logic       at_end;

   modport source (output valid, output delay, output direction, output at_end,
                   input ready);
   modport sink   (input valid, input delay, input direction, input at_end,
                   output ready);
endinterface

// ----- src/srdg_div.sv -----
// ----------------------------------------------------------------------------
// srdg_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srdg_div
   import srdg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_W-1:0]     dsr_ff, dsr_in;
   logic [DIV_W:0]       rem_sh;

   // shift in the next dividend bit and try the subtract
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      rem_sh  = {rem_ff, quo_ff[DIV_W-1]};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dsr_ff}) begin
            rem_in = DIV_W'(rem_sh - {1'b0, dsr_ff});
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ----- src/srdg_ctrl.sv -----
// ----------------------------------------------------------------------------
// srdg_ctrl
// Step sequencer: position and direction state, ramp selection, result word.
// ----------------------------------------------------------------------------
module srdg_ctrl
   import srdg_pkg::*;
#(
   parameter int POS_WIDTH = POS_WIDTH_DEF
)
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   srdg_req_if.sink     req_ch,
   srdg_rsp_if.source   rsp_ch,
   output div_req_type  div_req,
   input  div_rsp_type  div_rsp
);

   localparam int CMP_W = (POS_WIDTH > DIV_W) ? POS_WIDTH : DIV_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RAMP  = 3'd1;
   localparam logic [2:0] ST_SEL   = 3'd2;
   localparam logic [2:0] ST_DELAY = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   logic                 dir_ff, dir_in;
   logic [DIV_W-1:0]     ramp_ff, ramp_in;
   logic [7:0]           res_delay_ff, res_delay_in;
   logic                 res_hit_ff, res_hit_in;
   logic                 out_valid_ff, out_valid_in;
   logic [7:0]           out_delay_ff, out_delay_in;
   logic                 out_dir_ff, out_dir_in;
   logic                 out_hit_ff, out_hit_in;

   logic                 accept;
   logic [CMP_W-1:0]     pos_ext, tot_ext, ramp_ext, half_ext, rel_ext, dist_ext;
   logic [CMP_W:0]       rel_ramp_sum;
   logic [DIV_W-1:0]     ramp_dividend;

   assign accept = req_ch.valid && req_ch.ready;

   // 255 * steps_per_rev as a shift and subtract
   assign ramp_dividend = ({8'd0, cfg.steps_per_rev} << 8) - {8'd0, cfg.steps_per_rev};

   // operands of the ramp selection, at one common width
   assign pos_ext      = CMP_W'(pos_ff);
   assign tot_ext      = CMP_W'(cfg.end_pos);
   assign ramp_ext     = CMP_W'(ramp_ff);
   assign half_ext     = tot_ext >> 1;
   assign rel_ext      = (pos_ext == '0) ? CMP_W'(1) : pos_ext;
   assign dist_ext     = tot_ext - rel_ext;
   assign rel_ramp_sum = {1'b0, rel_ext} + {1'b0, ramp_ext};

   // sequence one step through the shared divider
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      dir_in       = dir_ff;
      ramp_in      = ramp_ff;
      res_delay_in = res_delay_ff;
      res_hit_in   = res_hit_ff;
      out_valid_in = out_valid_ff;
      out_delay_in = out_delay_ff;
      out_dir_in   = out_dir_ff;
      out_hit_in   = out_hit_ff;
      div_req      = '0;

      if (out_valid_ff && rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_ch.restart) begin
                  pos_in = '0;
                  dir_in = 1'b0;
               end
               div_req.start    = 1'b1;
               div_req.dividend = ramp_dividend;
               div_req.divisor  = (cfg.accel == '0) ? DIV_W'(1) : DIV_W'(cfg.accel);
               state_in         = ST_RAMP;
            end
         end
         ST_RAMP: begin
            if (div_rsp.done) begin
               ramp_in  = div_rsp.quotient;
               state_in = ST_SEL;
            end
         end
         ST_SEL: begin
            res_hit_in = 1'b0;
            if (pos_ext >= tot_ext) begin
               // end of move: slowest delay, reverse
               res_delay_in = MAX_DELAY;
               res_hit_in   = 1'b1;
               dir_in       = ~dir_ff;
               pos_in       = '0;
               state_in     = ST_DONE;
            end else begin
               pos_in           = pos_ff + 1'b1;
               div_req.dividend = ramp_ff;
               if (half_ext <= ramp_ext) begin
                  // short move: switch at the half-way point
                  div_req.start   = 1'b1;
                  div_req.divisor = (rel_ext <= half_ext) ? rel_ext[DIV_W-1:0]
                                                          : dist_ext[DIV_W-1:0];
                  state_in        = ST_DELAY;
               end else if (rel_ext <= ramp_ext) begin
                  div_req.start   = 1'b1;
                  div_req.divisor = rel_ext[DIV_W-1:0];
                  state_in        = ST_DELAY;
               end else if (rel_ramp_sum >= {1'b0, tot_ext}) begin
                  div_req.start   = 1'b1;
                  div_req.divisor = dist_ext[DIV_W-1:0];
                  state_in        = ST_DELAY;
               end else begin
                  // cruise
                  res_delay_in = MIN_DELAY;
                  state_in     = ST_DONE;
               end
            end
         end
         ST_DELAY: begin
            if (div_rsp.done) begin
               res_delay_in = clamp_delay(div_rsp.quotient);
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!out_valid_ff || rsp_ch.ready) begin
               out_valid_in = 1'b1;
               out_delay_in = res_delay_ff;
               out_dir_in   = dir_ff;
               out_hit_in   = res_hit_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         dir_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         dir_ff       <= dir_in;
         out_valid_ff <= out_valid_in;
      end
      ramp_ff      <= ramp_in;
      res_delay_ff <= res_delay_in;
      res_hit_ff   <= res_hit_in;
      out_delay_ff <= out_delay_in;
      out_dir_ff   <= out_dir_in;
      out_hit_ff   <= out_hit_in;
   end

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.delay     = out_delay_ff;
   assign rsp_ch.direction = out_dir_ff;
   assign rsp_ch.at_end    = out_hit_ff;

   // an accepted word starts the ramp division
   a_accept_starts_div: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_RAMP) && div_rsp.busy)
      else $error("accepted word did not start the ramp division");

   // the delay division finishes only on the divider's done
   a_delay_waits_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DELAY) && !div_rsp.done |=> state_ff == ST_DELAY)
      else $error("delay state left before division finished");

   // a delivered delay is never zero
   a_delay_nonzero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_delay_ff != 8'd0)
      else $error("zero delay on response");

   // an end-of-move word carries the slowest delay
   a_end_slowest: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_hit_ff |-> out_delay_ff == MAX_DELAY)
      else $error("end-of-move word without slowest delay");

endmodule

// ----- src/stepper_ramp_delay_generator.sv -----
// ----------------------------------------------------------------------------
// stepper_ramp_delay_generator
// Trapezoidal ramp step delay generator for a stepper motor.
// ----------------------------------------------------------------------------
// Each word on req_ch is one step request; restart = 1 clears position and
// direction before the step. Each request yields exactly one word on rsp_ch:
// the step delay (1 fastest .. 255 slowest), the direction after any
// reversal, and at_end when the step reached end_pos.
// Registers steps_per_rev, accel and end_pos are written through csr_wr_en,
// csr_index and csr_data, one write per cycle; the user must write them only
// while no step is in flight, as the block itself does not enforce it.
// One shared restoring divider does all the divisions, one quotient bit per
// cycle. A ramp step needs two divisions (ramp length, then the delay); a
// cruise or end-of-move step needs only the first.
// req_ch.ready is high only between steps, so a new request is accepted only
// once the previous step has been handed to the output register.
// Reset clears position and direction, the divider control state and the
// output valid flag, and restores the register defaults. A stalled receiver
// holds the response word in the output register; the next step may run
// meanwhile and waits for that register to drain before it completes.
// ----------------------------------------------------------------------------
module stepper_ramp_delay_generator
   import srdg_pkg::*;
#(
   parameter int POS_WIDTH = POS_WIDTH_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   srdg_req_if.sink             req_ch,
   srdg_rsp_if.source           rsp_ch,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   logic [15:0] spr_ff, spr_in;
   logic [7:0]  accel_ff, accel_in;
   logic [23:0] end_pos_ff, end_pos_in;
   cfg_type     cfg;
   div_req_type div_req;
   div_rsp_type div_rsp;

   // decode register writes; unknown indexes are dropped
   always_comb begin
      spr_in     = spr_ff;
      accel_in   = accel_ff;
      end_pos_in = end_pos_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_STEPS_PER_REV: spr_in     = csr_data[15:0];
            CSR_ACCEL:         accel_in   = csr_data[7:0];
            CSR_END_POS:       end_pos_in = csr_data[23:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spr_ff     <= SPR_RESET;
         accel_ff   <= ACCEL_RESET;
         end_pos_ff <= END_POS_RESET;
      end else begin
         spr_ff     <= spr_in;
         accel_ff   <= accel_in;
         end_pos_ff <= end_pos_in;
      end
   end

   assign cfg.steps_per_rev = spr_ff;
   assign cfg.accel         = accel_ff;
   assign cfg.end_pos       = end_pos_ff;

   srdg_ctrl #(
      .POS_WIDTH (POS_WIDTH)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   srdg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: stepper ramp delay generator testbench
// Sends step requests over the request channel, predicts every step record
// (delay, direction, end flag) from its own copy of position, direction and
// registers, and checks each record on the response channel in order.
// Registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top
   import srdg_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic restart;
      bit   hold;      // wait for every outstanding record before sending
   } step_item_type;

   typedef struct packed {
      logic [7:0] delay;
      logic       direction;
      logic       at_end;
   } step_rec_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_data;

   srdg_req_if req_ch ();
   srdg_rsp_if rsp_ch ();

   stepper_ramp_delay_generator dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // predictor state: registers, position and direction
   cfg_type                  cfg = '{SPR_RESET, ACCEL_RESET, END_POS_RESET};
   logic [POS_WIDTH_DEF-1:0] pos_state = '0;
   logic                     dir_state = 1'b0;

   step_item_type pending_steps[$];
   step_rec_type  expected_records[$];
   logic       req_taken = 1'b0;
   int         idle_pct = 13;
   int         fail_count = 0;
   int         words_sent = 0;
   int         move_ends = 0;
   int         restarts = 0;
   int         settings_used = 0;

   // advance the step position and work out the record this step yields
   function automatic step_rec_type next_step_record(input logic restart);
      logic [31:0]  div, ramp, pos, tot, half, rel, q;
      step_rec_type rec;
      div  = (cfg.accel == 8'd0) ? 32'd1 : 32'(cfg.accel);
      ramp = (32'd255 * 32'(cfg.steps_per_rev)) / div;
      if (restart) begin
         pos_state = '0;
         dir_state = 1'b0;
      end
      pos = 32'(pos_state);
      tot = 32'(cfg.end_pos);
      rec.at_end = 1'b0;
      if (pos >= tot) begin
         // end of move: slowest delay, reverse, back to zero
         rec.delay  = MAX_DELAY;
         dir_state  = ~dir_state;
         pos_state  = '0;
         rec.at_end = 1'b1;
      end else begin
         rel  = (pos == 32'd0) ? 32'd1 : pos;
         half = tot / 32'd2;
         if (half <= ramp) begin
            // short move: switch formulas at the half-way point
            q = (rel <= half) ? ramp / rel : ramp / (tot - rel);
         end else if (rel <= ramp) begin
            q = ramp / rel;
         end else if (rel >= tot - ramp) begin
            q = ramp / (tot - rel);
         end else begin
            q = 32'd1;
         end
         rec.delay = (q > 32'd255) ? MAX_DELAY : (q == 32'd0) ? MIN_DELAY : q[7:0];
         pos_state = POS_WIDTH_DEF'(pos + 32'd1);
      end
      rec.direction = dir_state;
      return rec;
   endfunction

   // clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // request driver: hold a word until taken, otherwise offer the next one
   always @(negedge clock) begin
      step_item_type itm;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (req_ch.valid && !req_taken) begin
         // hold the word until the block takes it
      end else if (pending_steps.size() != 0 && $urandom_range(99) >= idle_pct &&
                   !(pending_steps[0].hold && expected_records.size() != 0)) begin
         itm = pending_steps.pop_front();
         req_ch.valid   <= 1'b1;
         req_ch.restart <= itm.restart;
      end else begin
         req_ch.valid   <= 1'b0;
         req_ch.restart <= 1'($urandom_range(1));
      end
   end

   // response side: stall at random
   always @(negedge clock) begin
      rsp_ch.ready <= !reset && ($urandom_range(99) >= idle_pct);
   end

   // monitor: predict on each accepted request, check each accepted record
   always @(posedge clock) begin
      step_rec_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.restart) restarts++;
            expected_records.push_back(next_step_record(req_ch.restart));
            words_sent++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_records.size() == 0) begin
               $error("step record with none expected: delay %0d direction %0b at_end %0b",
                      rsp_ch.delay, rsp_ch.direction, rsp_ch.at_end);
               fail_count++;
            end else begin
               want = expected_records.pop_front();
               if (want.at_end) move_ends++;
               if (rsp_ch.delay !== want.delay) begin
                  $error("delay: expected %0d, actual %0d", want.delay, rsp_ch.delay);
                  fail_count++;
               end
               if (rsp_ch.direction !== want.direction) begin
                  $error("direction: expected %0b, actual %0b",
                         want.direction, rsp_ch.direction);
                  fail_count++;
               end
               if (rsp_ch.at_end !== want.at_end) begin
                  $error("at_end: expected %0b, actual %0b", want.at_end, rsp_ch.at_end);
                  fail_count++;
               end
            end
         end
      end
   end

   // wait until every queued word is sent and every record has come back
   task automatic settle();
      do @(negedge clock);
      while (pending_steps.size() != 0 || req_ch.valid || expected_records.size() != 0);
   endtask

   // write all three registers while the block is idle
   task automatic apply_settings(input logic [15:0] spr, input logic [7:0] acc,
                                 input logic [23:0] endp);
      settle();
      repeat (4) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_STEPS_PER_REV;
      csr_data  <= CFG_W'(spr);
      @(negedge clock);
      csr_index <= CSR_ACCEL;
      csr_data  <= CFG_W'(acc);
      @(negedge clock);
      csr_index <= CSR_END_POS;
      csr_data  <= CFG_W'(endp);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cfg = '{spr, acc, endp};
      settings_used++;
   endtask

   task automatic add_step(input logic restart, input bit hold);
      pending_steps.push_back('{restart, hold});
   endtask

   // stimulus
   initial begin
      logic [15:0] spr;
      logic [7:0]  acc;
      logic [23:0] endp;
      int          n;
      int          random_items;
      int          directed_words;
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_STEPS_PER_REV;
      csr_data       = '0;
      req_ch.valid   = 1'b0;
      req_ch.restart = 1'b0;
      rsp_ch.ready   = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset defaults: position zero taken as one, large quotient saturates
      add_step(1'b1, 1'b0);
      repeat (3) add_step(1'b0, 1'b0);

      // widest registers, then an end position of zero: every step ends
      apply_settings(16'hFFFF, 8'd1, 24'hFFFFFF);
      repeat (2) add_step(1'b0, 1'b0);
      apply_settings(16'hFFFF, 8'd1, 24'd0);
      repeat (2) add_step(1'b0, 1'b0);

      // zero accel taken as one; run a short move through to its end
      apply_settings(16'd1, 8'd0, 24'd6);
      add_step(1'b1, 1'b0);
      repeat (6) add_step(1'b0, 1'b0);

      // tiny ramp: every delay is the fastest; then shrink end below position
      apply_settings(16'd1, 8'd255, 24'd40);
      add_step(1'b1, 1'b0);
      repeat (4) add_step(1'b0, 1'b0);
      apply_settings(16'd1, 8'd255, 24'd2);
      add_step(1'b0, 1'b1);
      add_step(1'b0, 1'b0);
      settle();
      directed_words = words_sent;

      // random phases: mostly short moves with small ramps
      random_items = 0;
      for (int ph = 0; random_items < 1150; ph++) begin
         spr  = ($urandom_range(9) == 0) ? 16'($urandom_range(65535, 1))
                                         : 16'($urandom_range(40, 1));
         acc  = ($urandom_range(19) == 0) ? 8'd0
              : ($urandom_range(3) == 0)  ? 8'($urandom_range(255, 1))
                                          : 8'($urandom_range(255, 60));
         case ($urandom_range(19))
            0:       endp = 24'd0;
            1:       endp = 24'($urandom_range(24'hFFFFFF, 1000));
            default: endp = 24'($urandom_range(300, 2));
         endcase
         apply_settings(spr, acc, endp);
         idle_pct = (ph == 3) ? 0 : 13;
         n = (ph == 3) ? 200 : $urandom_range(120, 20);
         for (int i = 0; i < n; i++) begin
            add_step($urandom_range(99) < 3, $urandom_range(99) < 2);
         end
         random_items += n;
      end

      settle();
      repeat (80) @(posedge clock);
      $display("Covered %0d step words (%0d directed) over %0d register settings,",
               words_sent, directed_words, settings_used);
      $display("with %0d move ends and %0d restarts.", move_ends, restarts);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // guard against a hung handshake
   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
